// ===== rtl/core/ps2mpt_pkg.sv =====
// Package for the PS/2 mouse packet tracker: header bit masks, reset values,
// register indexes, framer phase type and the packet beat struct.
// No dependencies.
package ps2mpt_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int COORD_BITS_DEF = 12;
    localparam int CELL_SHIFT_DEF = 3;

    // Span registers and configuration port
    localparam int SPAN_W      = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = SPAN_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_X_SPAN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_SPAN = 2'd1;

    localparam logic [SPAN_W-1:0] X_SPAN_RESET = SPAN_W'(80 * 8);
    localparam logic [SPAN_W-1:0] Y_SPAN_RESET = SPAN_W'(25 * 8);
    localparam int POS_X_RESET = 40 * 8;
    localparam int POS_Y_RESET = 12 * 8;

    // Header byte bits
    localparam logic [7:0] HDR_LEFT  = 8'h01;
    localparam logic [7:0] HDR_SYNC  = 8'h08;
    localparam logic [7:0] HDR_XSIGN = 8'h10;
    localparam logic [7:0] HDR_YSIGN = 8'h20;
    localparam logic [7:0] HDR_XOVF  = 8'h40;
    localparam logic [7:0] HDR_YOVF  = 8'h80;

    // 9-bit deltas, Y negated: needs one more bit for +256
    localparam int DELTA_W = 10;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } phase_t;

    // Framer to tracker: a good packet finishes on this byte
    typedef struct packed {
        logic                      done;
        logic                      left;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } pkt_t;

endpackage

// ===== rtl/core/ps2mpt_framer.sv =====
// Byte framer: phase state machine, held header and X delta byte.
// Flags a good packet and hands out screen-oriented deltas.
// Depends on ps2mpt_pkg.
module ps2mpt_framer
    import ps2mpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_in,
    output pkt_t       pkt
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] header_reg;
    logic [7:0] header_next;
    logic [7:0] xdelta_reg;
    logic [7:0] xdelta_next;
    logic signed [DELTA_W-1:0] dy_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            xdelta_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xdelta_reg <= xdelta_next;
        end
    end

    assign dy_raw = {|(header_reg & HDR_YSIGN), |(header_reg & HDR_YSIGN), data_in};

    always_comb
    begin
        phase_next  = PH_HEADER;
        header_next = header_reg;
        xdelta_next = xdelta_reg;
        pkt         = '0;
        unique case (phase_reg)
            PH_XDELTA:
            begin
                xdelta_next = data_in;
                phase_next  = PH_YDELTA;
            end
            PH_YDELTA:
            begin
                phase_next = PH_HEADER;
                // overflowed packets are dropped outright
                pkt.done = ((header_reg & (HDR_XOVF | HDR_YOVF)) == 8'h00);
                pkt.left = |(header_reg & HDR_LEFT);
                pkt.dx   = {|(header_reg & HDR_XSIGN), |(header_reg & HDR_XSIGN),
                            xdelta_reg};
                pkt.dy   = -dy_raw;     // screen Y grows downward
            end
            default:
            begin
                // waiting for a header: only bytes with the sync bit start one
                if (|(data_in & HDR_SYNC))
                begin
                    header_next = data_in;
                    phase_next  = PH_XDELTA;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/ps2mpt_axis.sv =====
// One axis of pointer motion: add a signed delta and clamp to [0, span-1].
// Span of zero acts as one, span past the coordinate range acts as the range.
// Depends on ps2mpt_pkg.
module ps2mpt_axis
    import ps2mpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic [COORD_BITS-1:0]     pos,
    input  logic signed [DELTA_W-1:0] delta,
    input  logic [SPAN_W-1:0]         span,
    output logic [COORD_BITS-1:0]     pos_new
);

    localparam int WIDE_W = ((COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W) + 2;

    logic [WIDE_W-1:0]        range_w;
    logic [WIDE_W-1:0]        span_w;
    logic [WIDE_W-1:0]        limit;
    logic [WIDE_W-1:0]        limit_m1;
    logic signed [WIDE_W-1:0] sum;

    assign range_w  = WIDE_W'(1) << COORD_BITS;
    assign span_w   = WIDE_W'(span);
    assign sum      = $signed(WIDE_W'(pos)) + WIDE_W'(delta);
    assign limit_m1 = limit - WIDE_W'(1);

    always_comb
    begin
        priority if (span_w == '0)
            limit = WIDE_W'(1);
        else if (span_w > range_w)
            limit = range_w;
        else
            limit = span_w;
    end

    always_comb
    begin
        priority if (sum[WIDE_W-1])
            pos_new = '0;
        else if ($unsigned(sum) >= limit)
            pos_new = limit_m1[COORD_BITS-1:0];
        else
            pos_new = sum[COORD_BITS-1:0];
    end

endmodule

// ===== rtl/core/ps2mpt_tracker.sv =====
// Position tracker: input byte register, framer, two axis clamps, pointer
// position registers and the result register with its handshake.
// Depends on ps2mpt_pkg, ps2mpt_framer, ps2mpt_axis.
module ps2mpt_tracker
    import ps2mpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  data_valid,
    output logic                  data_ready,
    input  logic [7:0]            data_byte,
    input  logic [SPAN_W-1:0]     x_span,
    input  logic [SPAN_W-1:0]     y_span,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  left_pressed
);

    localparam int CMP_W = ((COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W) + 1;

    logic                  in_vld_reg;
    logic [7:0]            in_byte_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_x_next;
    logic [COORD_BITS-1:0] pos_y_next;
    logic                  res_vld_reg;
    logic [COORD_BITS-1:0] res_x_reg;
    logic [COORD_BITS-1:0] res_y_reg;
    logic                  res_left_reg;
    logic                  advance;
    logic                  step;
    logic                  load;
    pkt_t                  pkt;

    // the held byte moves on whenever the result slot is free or emptying
    assign advance    = !res_vld_reg || result_ready;
    assign step       = in_vld_reg && advance;
    assign load       = step && pkt.done;
    assign data_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (data_ready)
            in_vld_reg <= data_valid;
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
            in_byte_reg <= data_byte;
    end

    ps2mpt_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .data_in (in_byte_reg),
        .pkt     (pkt)
    );

    ps2mpt_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .pos     (pos_x_reg),
        .delta   (pkt.dx),
        .span    (x_span),
        .pos_new (pos_x_next)
    );

    ps2mpt_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .pos     (pos_y_reg),
        .delta   (pkt.dy),
        .span    (y_span),
        .pos_new (pos_y_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= COORD_BITS'(POS_X_RESET);
            pos_y_reg   <= COORD_BITS'(POS_Y_RESET);
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (advance)
                res_vld_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_x_reg    <= pos_x_next;
            res_y_reg    <= pos_y_next;
            res_left_reg <= pkt.left;
        end
    end

    assign result_valid = res_vld_reg;
    assign pixel_x      = res_x_reg;
    assign pixel_y      = res_y_reg;
    assign left_pressed = res_left_reg;

    // a held position never leaves the span it was clamped against
    a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (pos_x_reg == '0 || CMP_W'(pos_x_reg) < $past(CMP_W'(x_span))) &&
                 (pos_y_reg == '0 || CMP_W'(pos_y_reg) < $past(CMP_W'(y_span))))
        else $error("tracked position outside its span");

endmodule

// ===== rtl/core/ps2_mouse_packet_tracker.sv =====
// Top level of the PS/2 mouse packet tracker: span registers, configuration
// port and tracker core, plus the block's assertions.
// Depends on ps2mpt_pkg, ps2mpt_tracker (ps2mpt_framer, ps2mpt_axis).
//
// Takes raw PS/2 mouse bytes, one beat each on the data channel, and frames
// them into three-byte packets (header, X delta, Y delta). While hunting for
// a header, any byte without bit 3 set is discarded. A packet whose header
// has either overflow bit set is dropped and leaves the pointer where it was.
// A good packet adds its 9-bit X delta and subtracts its 9-bit Y delta (top
// of screen is zero), clamps each axis to [0, span-1], and emits one result
// beat: pixel position, character cell (pixel >> CELL_SHIFT) and the left
// button. Header and X delta bytes give no result. Spans are written through
// cfg_we/cfg_index/cfg_data while the block is idle; a span of zero pins the
// axis at 0, a span past 2**COORD_BITS acts as the full range, and a position
// left outside a lowered span is clamped on the next good packet. Reset puts
// the pointer at (320, 96) with spans 640 x 200.
// Throughput is one byte per clock unless the output stalls: a byte is held in
// the input register, the framer and clamp adders settle behind it, and the
// result lands in the output register, so result_valid rises once the Y delta
// byte has moved on from the input register, and the result beat can then be taken.
// The input stays open while a result waits, as long as the input register
// is empty; it stalls only when both the input register and the result
// register are full and the result is not being taken.
module ps2_mouse_packet_tracker
    import ps2mpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CELL_SHIFT = CELL_SHIFT_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [CFG_INDEX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data,
    input  logic                             data_valid,
    output logic                             data_ready,
    input  logic [7:0]                       data_byte,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [COORD_BITS-1:0]            pixel_x,
    output logic [COORD_BITS-1:0]            pixel_y,
    output logic [COORD_BITS-CELL_SHIFT-1:0] cell_x,
    output logic [COORD_BITS-CELL_SHIFT-1:0] cell_y,
    output logic                             left_pressed
);

    logic [SPAN_W-1:0] x_span_reg;
    logic [SPAN_W-1:0] y_span_reg;

    // span registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_span_reg <= X_SPAN_RESET;
            y_span_reg <= Y_SPAN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_SPAN: x_span_reg <= cfg_data;
                CFG_Y_SPAN: y_span_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    ps2mpt_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .x_span       (x_span_reg),
        .y_span       (y_span_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .left_pressed (left_pressed)
    );

    // character cell is just the upper pixel bits
    assign cell_x = pixel_x[COORD_BITS-1:CELL_SHIFT];
    assign cell_y = pixel_y[COORD_BITS-1:CELL_SHIFT];

    // a new result needs a byte to have been held in the input register
    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(u_tracker.in_vld_reg))
        else $error("result beat with no byte behind it");

    // a byte consumed with nothing new arriving empties the input register
    a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (u_tracker.step && !(data_valid && data_ready)) |=> !u_tracker.in_vld_reg)
        else $error("input register kept a consumed byte");

    // a held result blocks the input only when a byte is also waiting
    a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
        !data_ready |-> (result_valid && !result_ready))
        else $error("input stalled with the result slot free");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for ps2_mouse_packet_tracker: byte driver, result monitor
// and a pointer tracker that predicts every result beat.
// Depends on ps2mpt_pkg and the RTL of ps2_mouse_packet_tracker.
module tb_top;

    import ps2mpt_pkg::*;

    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int CELL_W       = COORD_BITS_DEF - CELL_SHIFT_DEF;
    localparam int SETTLE_CYCLES = 8;       // trailing wait once all results are back
    localparam int HOLD_CYCLES  = 400;      // long output stall to back up the input
    localparam int CYCLE_LIMIT  = 100000;

    // Indexes past the two span registers; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    // One expected result beat
    typedef struct {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [CELL_W-1:0]  cx;
        logic [CELL_W-1:0]  cy;
        logic               left;
    } pointer_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   data_valid = 1'b0;
    logic                   data_ready;
    logic [7:0]             data_byte = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [COORD_W-1:0]     pixel_x;
    logic [COORD_W-1:0]     pixel_y;
    logic [CELL_W-1:0]      cell_x;
    logic [CELL_W-1:0]      cell_y;
    logic                   left_pressed;

    // Bytes waiting to go out, and pointer positions waiting to come back
    logic [7:0] byte_q [$];
    pointer_t   pointer_q [$];

    // Tracker copy of the block's state and span registers
    phase_t             frame_ph   = PH_HEADER;
    logic [7:0]         hdr_byte   = '0;
    logic [7:0]         xlow_byte  = '0;
    logic [COORD_W-1:0] cur_x      = COORD_W'(POS_X_RESET);
    logic [COORD_W-1:0] cur_y      = COORD_W'(POS_Y_RESET);
    logic [SPAN_W-1:0]  span_x     = X_SPAN_RESET;
    logic [SPAN_W-1:0]  span_y     = Y_SPAN_RESET;

    // Pacing knobs, changed by the sequence between tests
    int unsigned send_pct = 32;
    int unsigned recv_pct = 51;
    logic        hold_arm = 1'b0;
    logic        hold_fired;
    int unsigned hold_left;

    int unsigned err_cnt      = 0;
    int unsigned bytes_sent   = 0;
    int unsigned moves_seen   = 0;
    int unsigned pkts_dropped = 0;
    int unsigned cyc_cnt      = 0;

    ps2_mouse_packet_tracker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .left_pressed (left_pressed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Single reset at the start of the run
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Move one axis by a delta and pin it inside [0, span-1].
    // Span 0 acts as 1; spans past the coordinate range act as the full range.
    function automatic logic [COORD_W-1:0] clamp_axis(logic [COORD_W-1:0] pos, int delta,
                                                    logic [SPAN_W-1:0] span);
        int lim;
        int nxt;
        lim = span;
        if (lim < 1)
            lim = 1;
        if (lim > (1 << COORD_W))
            lim = 1 << COORD_W;
        nxt = pos;
        nxt = nxt + delta;
        if (nxt < 0)
            nxt = 0;
        if (nxt >= lim)
            nxt = lim - 1;
        return nxt[COORD_W-1:0];
    endfunction

    // 9-bit two's complement delta: sign lives in the header
    function automatic int delta9(logic [7:0] low, logic neg);
        int d;
        d = low;
        if (neg)
            d = d - 256;
        return d;
    endfunction

    // Framer and pointer tracking for one accepted byte. A good Y byte
    // queues the position the block has to report.
    task automatic track_byte(logic [7:0] b);
        pointer_t p;
        case (frame_ph)
            PH_XDELTA:
            begin
                xlow_byte = b;
                frame_ph  = PH_YDELTA;
            end
            PH_YDELTA:
            begin
                frame_ph = PH_HEADER;
                if ((hdr_byte & (HDR_XOVF | HDR_YOVF)) != 0)
                    pkts_dropped++;
                else
                begin
                    cur_x = clamp_axis(cur_x, delta9(xlow_byte, (hdr_byte & HDR_XSIGN) != 0),
                                       span_x);
                    cur_y = clamp_axis(cur_y, -delta9(b, (hdr_byte & HDR_YSIGN) != 0),
                                       span_y);
                    p.px   = cur_x;
                    p.py   = cur_y;
                    p.cx   = CELL_W'(cur_x >> CELL_SHIFT_DEF);
                    p.cy   = CELL_W'(cur_y >> CELL_SHIFT_DEF);
                    p.left = (hdr_byte & HDR_LEFT) != 0;
                    pointer_q.push_back(p);
                end
            end
            default:
            begin
                // hunting for a header; bytes without the sync bit are dropped
                frame_ph = PH_HEADER;
                if ((b & HDR_SYNC) != 0)
                begin
                    hdr_byte = b;
                    frame_ph = PH_XDELTA;
                end
            end
        endcase
    endtask

    // Driver: loads the next byte whenever the data slot is free, idling at
    // random per send_pct. Valid holds steady until the beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_valid <= 1'b0;
            data_byte  <= '0;
        end
        else
        begin
            if (data_valid && data_ready)
            begin
                track_byte(data_byte);
                bytes_sent++;
            end
            if (!data_valid || data_ready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_pct)
                begin
                    data_valid <= 1'b1;
                    data_byte  <= byte_q.pop_front();
                end
                else
                    data_valid <= 1'b0;
            end
        end
    end

    // Receiver: random ready per recv_pct, plus one long hold-off once armed
    // so the block fills up and has to stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_fired   <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_arm && !hold_fired)
        begin
            hold_fired   <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_pct);
    end

    // Monitor: every result beat is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pointer_q.size() == 0)
            begin
                $error("result beat with nothing expected: pixel_x %0d pixel_y %0d",
                       pixel_x, pixel_y);
                err_cnt++;
            end
            else
            begin
                if (pixel_x !== pointer_q[0].px)
                begin
                    $error("pixel_x: expected %0d, got %0d", pointer_q[0].px, pixel_x);
                    err_cnt++;
                end
                if (pixel_y !== pointer_q[0].py)
                begin
                    $error("pixel_y: expected %0d, got %0d", pointer_q[0].py, pixel_y);
                    err_cnt++;
                end
                if (cell_x !== pointer_q[0].cx)
                begin
                    $error("cell_x: expected %0d, got %0d", pointer_q[0].cx, cell_x);
                    err_cnt++;
                end
                if (cell_y !== pointer_q[0].cy)
                begin
                    $error("cell_y: expected %0d, got %0d", pointer_q[0].cy, cell_y);
                    err_cnt++;
                end
                if (left_pressed !== pointer_q[0].left)
                begin
                    $error("left_pressed: expected %0d, got %0d", pointer_q[0].left,
                           left_pressed);
                    err_cnt++;
                end
                void'(pointer_q.pop_front());
                moves_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc_cnt,
                     pointer_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_packet(logic [7:0] hdr, logic [7:0] xb, logic [7:0] yb);
        byte_q.push_back(hdr);
        byte_q.push_back(xb);
        byte_q.push_back(yb);
    endtask

    // Delta byte with extra weight on the values that hit the clamps
    function automatic logic [7:0] pick_delta();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(3) == 0)
            case ($urandom_range(3))
                0: v = 8'h00;
                1: v = 8'hFF;
                2: v = 8'h01;
                default: v = 8'h80;
            endcase
        return v;
    endfunction

    // Mostly well-formed packets with random content; the rest is stray
    // bytes that break framing. Overflow headers show up now and then.
    task automatic queue_traffic(int n_bytes);
        int         made;
        logic [7:0] hdr;
        logic [7:0] junk;
        made = 0;
        while (made < n_bytes)
        begin
            if ($urandom_range(99) < 12)
            begin
                junk = 8'($urandom);
                byte_q.push_back(junk);
                made++;
            end
            else
            begin
                hdr = 8'($urandom);
                hdr = hdr | HDR_SYNC;
                if ($urandom_range(99) < 85)
                    hdr = hdr & ~(HDR_XOVF | HDR_YOVF);
                queue_packet(hdr, pick_delta(), pick_delta());
                made += 3;
            end
        end
    endtask

    // Wait until every byte is taken and every result is back, then give
    // any trailing header/X byte time to clear the pipe.
    task automatic settle();
        @(negedge clk);
        while (byte_q.size() != 0 || data_valid || pointer_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only issued while the block is idle
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        if (idx == CFG_X_SPAN)
            span_x = val[SPAN_W-1:0];
        else if (idx == CFG_Y_SPAN)
            span_y = val[SPAN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Test sequence
    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);

        // Directed opening at reset spans 640 x 200, pointer at (320, 96)
        byte_q.push_back(8'h00);                    // stray byte, no sync
        byte_q.push_back(~HDR_SYNC);                // every bit but sync
        queue_packet(HDR_SYNC | HDR_LEFT | HDR_YSIGN, 8'hFF, 8'h00); // +255 right, +256 down
        queue_packet(HDR_SYNC | HDR_XSIGN, 8'h00, 8'h7F);  // -256 left, 127 up
        queue_packet(HDR_SYNC | HDR_XSIGN, 8'h01, 8'h7F);  // -255 left, pins top
        queue_packet(HDR_SYNC | HDR_XSIGN, 8'h01, 8'h00);  // pins left edge
        queue_packet(HDR_SYNC | HDR_XOVF, 8'h55, 8'hAA);   // X overflow: dropped
        queue_packet(HDR_SYNC | HDR_YOVF, 8'h12, 8'h34);   // Y overflow: dropped
        queue_packet(8'hFF, 8'hFF, 8'hFF);                 // both overflows: dropped
        queue_packet(8'h3F, 8'h80, 8'h80);                 // both signs, left held
        queue_traffic(300);
        settle();

        // Degenerate spans: X pinned at zero, Y beyond the coordinate range
        write_reg(CFG_X_SPAN, 0);
        write_reg(CFG_Y_SPAN, 8191);
        write_reg(CFG_SPARE_A, 13'h1FFF);
        @(negedge clk);
        queue_traffic(150);
        settle();

        // Swap pacing; full-range X and a one-row Y
        send_pct = 51;
        recv_pct = 32;
        write_reg(CFG_X_SPAN, 4096);
        write_reg(CFG_Y_SPAN, 1);
        write_reg(CFG_SPARE_B, 0);
        @(negedge clk);
        queue_traffic(250);
        settle();

        // Shrink both spans under the current pointer: next good packet clamps
        write_reg(CFG_X_SPAN, 17);
        write_reg(CFG_Y_SPAN, 9);
        @(negedge clk);
        queue_packet(HDR_SYNC, 8'h00, 8'h00);
        queue_traffic(200);
        settle();

        // No idling, plus the long receiver hold-off with the sender pushing
        send_pct = 0;
        recv_pct = 0;
        write_reg(CFG_X_SPAN, 4095);
        write_reg(CFG_Y_SPAN, 640);
        @(negedge clk);
        queue_traffic(250);
        hold_arm = 1'b1;
        settle();

        $display("%0d bytes sent over 5 span settings, %0d pointer moves checked,",
                 bytes_sent, moves_seen);
        $display("%0d overflow packets dropped, 3 pacing modes and a %0d-cycle output stall",
                 pkts_dropped, HOLD_CYCLES);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ps2mpt_pkg.sv
rtl/core/ps2mpt_framer.sv
rtl/core/ps2mpt_axis.sv
rtl/core/ps2mpt_tracker.sv
rtl/core/ps2_mouse_packet_tracker.sv
dv/tb_top.sv
